[rtl/triangle_box_clipper_unit_macros.svh]
`ifndef TRIANGLE_BOX_CLIPPER_UNIT_MACROS_SVH
`define TRIANGLE_BOX_CLIPPER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define TBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define TBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tbc_pkg.sv]
package tbc_pkg;

  localparam int COORD_W_DEF = 32;
  localparam int MAX_VERTS   = 9;
  localparam int IDX_W       = 4;
  localparam int NUM_REGS    = 6;
  localparam int NUM_PLANES  = 6;
  localparam int TRI_Q_DEPTH = 2;

  // register indexes
  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MAX_X = 3'd1;
  localparam logic [2:0] REG_MIN_Y = 3'd2;
  localparam logic [2:0] REG_MAX_Y = 3'd3;
  localparam logic [2:0] REG_MIN_Z = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;

  // clip planes in processing order
  localparam logic [2:0] PL_MIN_X = 3'd0;
  localparam logic [2:0] PL_MAX_X = 3'd1;
  localparam logic [2:0] PL_MIN_Z = 3'd2;
  localparam logic [2:0] PL_MAX_Z = 3'd3;
  localparam logic [2:0] PL_MIN_Y = 3'd4;
  localparam logic [2:0] PL_MAX_Y = 3'd5;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/tbc_if.sv]
interface tbc_vert_if #(parameter int W = tbc_pkg::COORD_W_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] vert_x;
  logic [W-1:0] vert_y;
  logic [W-1:0] vert_z;

  modport source(output valid, vert_x, vert_y, vert_z, input ready);
  modport sink(input valid, vert_x, vert_y, vert_z, output ready);
endinterface

interface tbc_res_if #(parameter int W = tbc_pkg::COORD_W_DEF);
  import tbc_pkg::*;
  logic             valid;
  logic             ready;
  logic [W-1:0]     out_x;
  logic [W-1:0]     out_y;
  logic [W-1:0]     out_z;
  logic [IDX_W-1:0] out_index;
  logic             is_empty;
  logic             is_last;

  modport source(output valid, out_x, out_y, out_z, out_index, is_empty, is_last,
                 input ready);
  modport sink(input valid, out_x, out_y, out_z, out_index, is_empty, is_last,
               output ready);
endinterface

[rtl/triangle_box_clipper_unit.sv]
// Clips a triangle, given as three vertex words, against the axis-aligned box held in
// six registers (min x, max x, min y, max y, min z, max z at byte addresses 0..20, or
// 0..40 when coordinates are wider than 32 bits) and returns the clipped polygon as
// 1..9 result words, or a single word marked empty when the triangle is culled. Planes
// are tested in the order min x, max x, min z, max z, min y, max y; a vertex on a plane
// counts as inside. A front stage gathers vertices and hands whole triangles to a
// two-entry queue, so up to two triangles plus two vertices can be taken in while the
// clipper works. For each plane the clipper classifies the vertices, fetches the last
// one, and then tests each vertex in turn; each edge crossing adds a bit-serial multiply
// and restoring divide, run in lockstep by the three coordinate lanes. One result word
// then leaves per cycle, while the receiver is ready, through a registered output stage.
`include "triangle_box_clipper_unit_macros.svh"
module triangle_box_clipper_unit #(
  parameter int COORD_WIDTH = tbc_pkg::COORD_W_DEF,
  parameter int DATA_W      = (COORD_WIDTH > 32) ? 64 : 32,
  parameter int ADDR_W      = (COORD_WIDTH > 32) ? 6 : 5
) (
  input  logic              clk,
  input  logic              rst_n,
  tbc_vert_if.sink          in_vert,
  tbc_res_if.source         out_res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);
  import tbc_pkg::*;

  localparam int LSB = (DATA_W == 64) ? 3 : 2;

  logic [5:0][COORD_WIDTH-1:0]       box_r;
  logic [2:0]                        reg_idx;
  logic                              wr;
  logic                              tri_push, pop;
  logic [2:0][2:0][COORD_WIDTH-1:0]  tri_in, tri_out;
  fifo_stat_t                        fstat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[LSB+2:LSB];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= '0;
    end else if (wr && reg_idx < 3'(NUM_REGS)) begin
      box_r[reg_idx] <= pwdata[COORD_WIDTH-1:0];
    end
  end

  always_comb begin
    if (reg_idx < 3'(NUM_REGS)) begin
      prdata = DATA_W'(signed'(box_r[reg_idx]));
    end else begin
      prdata = '0;
    end
  end

  tbc_front #(.W(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vert  (in_vert),
    .fstat    (fstat),
    .tri_push (tri_push),
    .tri_data (tri_in)
  );

  tbc_tri_fifo #(.W(COORD_WIDTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (tri_push),
    .wdata (tri_in),
    .pop   (pop),
    .rdata (tri_out),
    .fstat (fstat)
  );

  tbc_clip #(.W(COORD_WIDTH)) u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .box      (box_r),
    .tri_data (tri_out),
    .fstat    (fstat),
    .pop      (pop),
    .out_res  (out_res)
  );

  `TBC_ASSERT_IMP(a_empty_alone, out_res.valid && out_res.is_empty, out_res.is_last && out_res.out_index == '0 && out_res.out_x == '0, "culled result is not a lone zero word")
  `TBC_ASSERT_IMP(a_index_range, out_res.valid, out_res.out_index < IDX_W'(MAX_VERTS), "result index beyond polygon size")
  `TBC_ASSERT_IMP(a_pop_safe, pop, !fstat.empty, "triangle taken from an empty queue")
  `TBC_ASSERT_NXT(a_reset_quiet, !rst_n, !out_res.valid, "result valid right after reset")

endmodule

[rtl/tbc_front.sv]
module tbc_front #(
  parameter int W = tbc_pkg::COORD_W_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  tbc_vert_if.sink                in_vert,
  input  tbc_pkg::fifo_stat_t     fstat,
  output logic                    tri_push,
  output logic [2:0][2:0][W-1:0]  tri_data
);
  import tbc_pkg::*;

  logic [1:0]           seen_r;
  logic [1:0][2:0][W-1:0] v_r;
  logic                 acc;
  logic [2:0][W-1:0]    cur;

  assign cur           = {in_vert.vert_z, in_vert.vert_y, in_vert.vert_x};
  // the third word needs a free queue slot, the first two are just stored
  assign in_vert.ready = (seen_r != 2'd2) || !fstat.full;
  assign acc           = in_vert.valid && in_vert.ready;
  assign tri_push      = acc && (seen_r == 2'd2);
  assign tri_data      = {cur, v_r[1], v_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
    end else if (acc) begin
      seen_r <= (seen_r == 2'd2) ? 2'd0 : seen_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && seen_r != 2'd2) begin
      v_r[seen_r[0]] <= cur;
    end
  end

endmodule

[rtl/tbc_tri_fifo.sv]
module tbc_tri_fifo #(
  parameter int W = tbc_pkg::COORD_W_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [2:0][2:0][W-1:0]  wdata,
  input  logic                    pop,
  output logic [2:0][2:0][W-1:0]  rdata,
  output tbc_pkg::fifo_stat_t     fstat
);
  import tbc_pkg::*;

  localparam int PW = (TRI_Q_DEPTH > 1) ? $clog2(TRI_Q_DEPTH) : 1;
  localparam int CW = $clog2(TRI_Q_DEPTH + 1);

  logic [2:0][2:0][W-1:0] mem_r [TRI_Q_DEPTH];
  logic [PW-1:0]          wp_r, rp_r;
  logic [CW-1:0]          cnt_r;

  assign fstat.full  = (cnt_r == CW'(TRI_Q_DEPTH));
  assign fstat.empty = (cnt_r == '0);
  assign rdata       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(TRI_Q_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(TRI_Q_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

[rtl/tbc_clip.sv]
module tbc_clip #(
  parameter int W = tbc_pkg::COORD_W_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [5:0][W-1:0]       box,
  input  logic [2:0][2:0][W-1:0]  tri_data,
  input  tbc_pkg::fifo_stat_t     fstat,
  output logic                    pop,
  tbc_res_if.source               out_res
);
  import tbc_pkg::*;

  localparam int DW = W + 1;
  localparam int SW = $clog2(DW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MARK  = 4'd1;
  localparam logic [3:0] S_LDPRV = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_TEST  = 4'd4;
  localparam logic [3:0] S_SETUP = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_WRX   = 4'd8;
  localparam logic [3:0] S_KEEP  = 4'd9;
  localparam logic [3:0] S_NEXT  = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  typedef logic [2:0][W-1:0] vert_t;

  function automatic logic signed [W:0] dist_f(input logic [2:0] pl, input vert_t v,
                                               input logic [5:0][W-1:0] bx);
    logic signed [W:0] c;
    logic signed [W:0] b;
    logic              lower;
    case (pl)
      PL_MIN_X: begin
        c = (W+1)'(signed'(v[0])); b = (W+1)'(signed'(bx[REG_MIN_X])); lower = 1'b1;
      end
      PL_MAX_X: begin
        c = (W+1)'(signed'(v[0])); b = (W+1)'(signed'(bx[REG_MAX_X])); lower = 1'b0;
      end
      PL_MIN_Z: begin
        c = (W+1)'(signed'(v[2])); b = (W+1)'(signed'(bx[REG_MIN_Z])); lower = 1'b1;
      end
      PL_MAX_Z: begin
        c = (W+1)'(signed'(v[2])); b = (W+1)'(signed'(bx[REG_MAX_Z])); lower = 1'b0;
      end
      PL_MIN_Y: begin
        c = (W+1)'(signed'(v[1])); b = (W+1)'(signed'(bx[REG_MIN_Y])); lower = 1'b1;
      end
      default: begin
        c = (W+1)'(signed'(v[1])); b = (W+1)'(signed'(bx[REG_MAX_Y])); lower = 1'b0;
      end
    endcase
    return lower ? (c - b) : (b - c);
  endfunction

  logic [3:0]       state_r;
  logic             sel_r;
  logic [3:0]       n_r, cnt_r, i_r;
  logic [2:0]       plane_r;
  logic [MAX_VERTS-1:0] marks_r;
  logic             anyin_r;
  vert_t            cur_r, prv_r, vin_r, vout_r;
  logic             curm_r, prvm_r;
  logic signed [W:0] din_r, dout_r;
  logic [DW-1:0]    den_r, mq_r;
  logic [SW-1:0]    step_r;
  vert_t            buf_r [2][MAX_VERTS];
  vert_t            res;

  logic             ov_r;
  vert_t            ov_data_r;
  logic [IDX_W-1:0] oidx_r;
  logic             oempty_r, olast_r;

  logic [3:0]       rd_idx;
  vert_t            rd_v;
  logic signed [W:0] d_rd;
  logic             out_free;
  logic             wr_en;
  vert_t            wr_data;

  always_comb begin
    case (state_r)
      S_LDPRV: rd_idx = n_r - 4'd1;
      default: rd_idx = i_r;
    endcase
  end

  assign rd_v     = buf_r[sel_r][rd_idx];
  assign d_rd     = dist_f(plane_r, rd_v, box);
  assign out_free = !ov_r || out_res.ready;
  assign pop      = (state_r == S_IDLE) && !fstat.empty;

  assign wr_en   = (state_r == S_WRX) ||
                   ((state_r == S_KEEP) && !curm_r && (cnt_r < 4'(MAX_VERTS)));
  assign wr_data = (state_r == S_WRX) ? res : cur_r;

  // each of the three lanes runs its own bit-serial multiply, then divide, in lockstep per crossing
  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [2*DW-1:0] acc_r;
    logic [DW-1:0]   mag_r;
    logic            neg_r;
    logic signed [DW-1:0] delta;
    logic [DW:0]     t;
    logic [DW:0]     t_sub;
    logic            ge;

    assign delta = (W+1)'(signed'(vout_r[k])) - (W+1)'(signed'(vin_r[k]));
    assign t     = {acc_r[2*DW-1:DW], acc_r[DW-1]};
    assign t_sub = t - {1'b0, den_r};
    assign ge    = (t >= {1'b0, den_r});
    assign res[k] = neg_r ? (vin_r[k] - acc_r[W-1:0]) : (vin_r[k] + acc_r[W-1:0]);

    always_ff @(posedge clk) begin
      case (state_r)
        S_SETUP: begin
          neg_r <= delta[DW-1];
          mag_r <= delta[DW-1] ? DW'(-delta) : DW'(delta);
          acc_r <= '0;
        end
        S_MUL: begin
          acc_r <= {acc_r[2*DW-2:0], 1'b0} + (mq_r[DW-1] ? {{DW{1'b0}}, mag_r} : '0);
        end
        S_DIV: begin
          // restoring step, quotient bits shift in at the bottom
          acc_r <= {(ge ? t_sub[DW-1:0] : t[DW-1:0]), acc_r[DW-2:0], ge};
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sel_r    <= 1'b0;
      n_r      <= 4'd0;
      cnt_r    <= 4'd0;
      i_r      <= 4'd0;
      plane_r  <= 3'd0;
      anyin_r  <= 1'b0;
      step_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (ov_r && out_res.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!fstat.empty) begin
            sel_r   <= 1'b0;
            n_r     <= 4'd3;
            plane_r <= PL_MIN_X;
            i_r     <= 4'd0;
            anyin_r <= 1'b0;
            state_r <= S_MARK;
          end
        end
        S_MARK: begin
          anyin_r <= anyin_r | !d_rd[W];
          if (i_r == n_r - 4'd1) begin
            i_r <= 4'd0;
            if (anyin_r || !d_rd[W]) begin
              state_r <= S_LDPRV;
            end else begin
              n_r     <= 4'd0;
              state_r <= S_EMIT;
            end
          end else begin
            i_r <= i_r + 4'd1;
          end
        end
        S_LDPRV: begin
          cnt_r   <= 4'd0;
          state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_TEST;
        end
        S_TEST: begin
          state_r <= ((curm_r != prvm_r) && (cnt_r < 4'(MAX_VERTS))) ? S_SETUP : S_KEEP;
        end
        S_SETUP: begin
          step_r  <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (step_r == SW'(DW - 1)) begin
            step_r  <= '0;
            state_r <= S_DIV;
          end else begin
            step_r <= step_r + SW'(1);
          end
        end
        S_DIV: begin
          if (step_r == SW'(DW - 1)) begin
            state_r <= S_WRX;
          end else begin
            step_r <= step_r + SW'(1);
          end
        end
        S_WRX: begin
          cnt_r   <= cnt_r + 4'd1;
          state_r <= S_KEEP;
        end
        S_KEEP: begin
          if (wr_en) begin
            cnt_r <= cnt_r + 4'd1;
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (i_r == n_r - 4'd1) begin
            sel_r   <= !sel_r;
            n_r     <= cnt_r;
            i_r     <= 4'd0;
            anyin_r <= 1'b0;
            plane_r <= plane_r + 3'd1;
            state_r <= (plane_r == PL_MAX_Y || cnt_r == 4'd0) ? S_EMIT : S_MARK;
          end else begin
            i_r     <= i_r + 4'd1;
            state_r <= S_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            ov_r <= 1'b1;
            if (n_r == 4'd0 || i_r == n_r - 4'd1) begin
              state_r <= S_IDLE;
            end else begin
              i_r <= i_r + 4'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && !fstat.empty) begin
      buf_r[0][0] <= tri_data[0];
      buf_r[0][1] <= tri_data[1];
      buf_r[0][2] <= tri_data[2];
    end
    if (wr_en) begin
      buf_r[!sel_r][cnt_r] <= wr_data;
    end
    if (state_r == S_MARK) begin
      marks_r[i_r] <= d_rd[W];
    end
    if (state_r == S_LDPRV) begin
      prv_r  <= rd_v;
      prvm_r <= marks_r[n_r - 4'd1];
    end
    if (state_r == S_RD) begin
      cur_r  <= rd_v;
      curm_r <= marks_r[i_r];
    end
    if (state_r == S_TEST) begin
      vin_r  <= curm_r ? prv_r : cur_r;
      vout_r <= curm_r ? cur_r : prv_r;
      din_r  <= dist_f(plane_r, curm_r ? prv_r : cur_r, box);
      dout_r <= dist_f(plane_r, curm_r ? cur_r : prv_r, box);
    end
    if (state_r == S_SETUP) begin
      den_r <= DW'(din_r - dout_r);
      mq_r  <= DW'(din_r);
    end else if (state_r == S_MUL) begin
      mq_r <= {mq_r[DW-2:0], 1'b0};
    end
    if (state_r == S_NEXT) begin
      prv_r  <= cur_r;
      prvm_r <= curm_r;
    end
    if (state_r == S_EMIT && out_free) begin
      if (n_r == 4'd0) begin
        ov_data_r <= '0;
        oidx_r    <= '0;
        oempty_r  <= 1'b1;
        olast_r   <= 1'b1;
      end else begin
        ov_data_r <= rd_v;
        oidx_r    <= IDX_W'(i_r);
        oempty_r  <= 1'b0;
        olast_r   <= (i_r == n_r - 4'd1);
      end
    end
  end

  assign out_res.valid     = ov_r;
  assign out_res.out_x     = ov_data_r[0];
  assign out_res.out_y     = ov_data_r[1];
  assign out_res.out_z     = ov_data_r[2];
  assign out_res.out_index = oidx_r;
  assign out_res.is_empty  = oempty_r;
  assign out_res.is_last   = olast_r;

endmodule

[sim/tb_triangle_box_clipper_unit.sv]
module tb_triangle_box_clipper_unit;
  import tbc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [3:0]  idx;
    logic        emp;
    logic        last;
  } clip_vert_t;

  // one directed word; box_sel >= 0 loads a box set before it, culled types the result
  typedef struct {
    int          box_sel;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          culled;
  } vert_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tbc_vert_if in_vert_if ();
  tbc_res_if  out_res_if ();

  triangle_box_clipper_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_vert(in_vert_if), .out_res(out_res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  clip_vert_t  clipped_q[$];
  longint      box_reg[NUM_REGS];
  longint      tri_vert[3][3];
  int          verts_held = 0;
  int          errors = 0;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_idle = 0;

  initial begin
    in_vert_if.valid = 1'b0;
    in_vert_if.vert_x = '0;
    in_vert_if.vert_y = '0;
    in_vert_if.vert_z = '0;
    out_res_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) out_res_if.ready <= ($urandom_range(99) >= recv_idle);

  // outputs only change at the rising edge, so the falling edge sees the handshake
  always @(negedge clk) begin
    clip_vert_t got, want;
    if (rst_n && out_res_if.valid && out_res_if.ready) begin
      got = '{out_res_if.out_x, out_res_if.out_y, out_res_if.out_z,
              out_res_if.out_index, out_res_if.is_empty, out_res_if.is_last};
      if (clipped_q.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h z=%h idx=%0d", $time,
                 got.x, got.y, got.z, got.idx);
        errors++;
      end else begin
        want = clipped_q.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: out_x expected %h actual %h", $time, want.x, got.x); errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t: out_y expected %h actual %h", $time, want.y, got.y); errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t: out_z expected %h actual %h", $time, want.z, got.z); errors++;
        end
        if (got.idx !== want.idx) begin
          $display("%0t: out_index expected %0d actual %0d", $time, want.idx, got.idx);
          errors++;
        end
        if (got.emp !== want.emp) begin
          $display("%0t: is_empty expected %b actual %b", $time, want.emp, got.emp);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: is_last expected %b actual %b", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  function automatic longint plane_dist(int pl, longint vx, longint vy, longint vz);
    case (3'(pl))
      PL_MIN_X: return vx - box_reg[REG_MIN_X];
      PL_MAX_X: return box_reg[REG_MAX_X] - vx;
      PL_MIN_Z: return vz - box_reg[REG_MIN_Z];
      PL_MAX_Z: return box_reg[REG_MAX_Z] - vz;
      PL_MIN_Y: return vy - box_reg[REG_MIN_Y];
      default:  return box_reg[REG_MAX_Y] - vy;
    endcase
  endfunction

  task automatic predict_clip();
    longint pa[MAX_VERTS][3];
    longint pb[MAX_VERTS][3];
    bit om[MAX_VERTS];
    int n, cnt, outs, p, vi, vo;
    longint din, dout, den, delta, mag, q;
    logic signed [127:0] prod;
    clip_vert_t r;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) pa[i][k] = tri_vert[i][k];
    n = 3;
    for (int pl = 0; pl < NUM_PLANES && n != 0; pl++) begin
      outs = 0;
      for (int i = 0; i < n; i++) begin
        om[i] = plane_dist(pl, pa[i][0], pa[i][1], pa[i][2]) < 0;
        outs += om[i];
      end
      if (outs == n) begin
        n = 0;
      end else begin
        cnt = 0;
        for (int i = 0; i < n; i++) begin
          p = (i != 0) ? i - 1 : n - 1;
          if (om[i] != om[p] && cnt < MAX_VERTS) begin
            vi = om[i] ? p : i;
            vo = om[i] ? i : p;
            din = plane_dist(pl, pa[vi][0], pa[vi][1], pa[vi][2]);
            dout = plane_dist(pl, pa[vo][0], pa[vo][1], pa[vo][2]);
            den = din - dout;
            for (int k = 0; k < 3; k++) begin
              delta = pa[vo][k] - pa[vi][k];
              mag = (delta < 0) ? -delta : delta;
              prod = 128'(mag) * 128'(din);
              q = 64'(prod / 128'(den));
              pb[cnt][k] = (delta < 0) ? pa[vi][k] - q : pa[vi][k] + q;
            end
            cnt++;
          end
          if (!om[i] && cnt < MAX_VERTS) begin
            for (int k = 0; k < 3; k++) pb[cnt][k] = pa[i][k];
            cnt++;
          end
        end
        n = cnt;
        for (int i = 0; i < n; i++)
          for (int k = 0; k < 3; k++) pa[i][k] = pb[i][k];
      end
    end
    if (n == 0) begin
      r = '{32'd0, 32'd0, 32'd0, 4'd0, 1'b1, 1'b1};
      clipped_q.push_back(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        r = '{pa[i][0][31:0], pa[i][1][31:0], pa[i][2][31:0], 4'(i), 1'b0, i == n - 1};
        clipped_q.push_back(r);
      end
    end
  endtask

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_vert(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit culled);
    bit hs;
    if ($urandom_range(99) < send_idle) begin
      in_vert_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_vert_if.valid <= 1'b1;
    in_vert_if.vert_x <= x;
    in_vert_if.vert_y <= y;
    in_vert_if.vert_z <= z;
    do begin
      @(negedge clk);
      hs = in_vert_if.ready;
      @(posedge clk);
    end while (!hs);
    tri_vert[verts_held][0] = longint'($signed(x));
    tri_vert[verts_held][1] = longint'($signed(y));
    tri_vert[verts_held][2] = longint'($signed(z));
    if (verts_held == 2) begin
      verts_held = 0;
      if (culled) clipped_q.push_back('{32'd0, 32'd0, 32'd0, 4'd0, 1'b1, 1'b1});
      else predict_clip();
    end else begin
      verts_held++;
    end
  endtask

  task automatic wait_idle();
    in_vert_if.valid <= 1'b0;
    while (clipped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves the bus in its access phase; the caller returns it to idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    box_reg[idx] = longint'($signed(val));
  endtask

  task automatic load_box(logic [31:0] lx, logic [31:0] hx, logic [31:0] ly,
                          logic [31:0] hy, logic [31:0] lz, logic [31:0] hz);
    wait_idle();
    write_reg(REG_MIN_X, lx);
    write_reg(REG_MAX_X, hx);
    write_reg(REG_MIN_Y, ly);
    write_reg(REG_MAX_Y, hy);
    write_reg(REG_MIN_Z, lz);
    write_reg(REG_MAX_Z, hz);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_coord(int bits);
    logic [31:0] r;
    r = $urandom;
    if (bits < 32) r = $signed(r << (32 - bits)) >>> (32 - bits);
    return r;
  endfunction

  // box sets for the directed rows: unit cube, then x inverted
  logic [31:0] dir_box[2][6] = '{
    '{32'hFFFF0000, 32'h00010000, 32'hFFFF0000, 32'h00010000, 32'hFFFF0000, 32'h00010000},
    '{32'h00000001, 32'hFFFFFFFF, 32'hFFFF0000, 32'h00010000, 32'hFFFF0000, 32'h00010000}
  };

  vert_row_t dir_rows[] = '{
    // zero box after reset: degenerate point triangle survives
    '{-1, 32'h0, 32'h0, 32'h0, 0},
    '{-1, 32'h0, 32'h0, 32'h0, 0},
    '{-1, 32'h0, 32'h0, 32'h0, 0},
    // all beyond max x
    '{-1, 32'h7FFFFFFF, 32'h0, 32'h0, 0},
    '{-1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 0},
    '{-1, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF, 1},
    // all below min x
    '{-1, 32'h80000000, 32'h80000000, 32'h80000000, 0},
    '{-1, 32'h80000000, 32'h0, 32'h80000000, 0},
    '{-1, 32'h80000000, 32'h80000000, 32'h0, 1},
    // two crossings on each of the max x and max y planes
    '{0, 32'h0, 32'h0, 32'h0, 0},
    '{-1, 32'h00030000, 32'h0, 32'h0, 0},
    '{-1, 32'h0, 32'h00030000, 32'h00008000, 0},
    // box inside triangle, many vertices
    '{-1, 32'hFFF00000, 32'hFFF00000, 32'h0, 0},
    '{-1, 32'h00300000, 32'hFFF80000, 32'h00004000, 0},
    '{-1, 32'hFFF80000, 32'h00300000, 32'hFFFFC000, 0},
    // vertices on the planes
    '{-1, 32'h00010000, 32'h0, 32'h0, 0},
    '{-1, 32'h00010000, 32'h00010000, 32'h00010000, 0},
    '{-1, 32'h0, 32'h0, 32'h00010000, 0},
    // extreme coordinates
    '{-1, 32'h7FFFFFFF, 32'h80000000, 32'h0, 0},
    '{-1, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0},
    '{-1, 32'h0, 32'h0, 32'h80000000, 0},
    // inverted x slab culls everything
    '{1, 32'h0, 32'h0, 32'h0, 0},
    '{-1, 32'h0, 32'h0, 32'h0, 0},
    '{-1, 32'h0, 32'h0, 32'h0, 1}
  };

  initial begin
    int idle_tx[3] = '{19, 65, 0};
    int idle_rx[3] = '{65, 19, 0};
    int kind, bits;
    logic [31:0] a, b, lo[3], hi[3];
    for (int i = 0; i < NUM_REGS; i++) box_reg[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = idle_tx[0];
    recv_idle = idle_rx[0];
    foreach (dir_rows[i]) begin
      if (dir_rows[i].box_sel >= 0)
        load_box(dir_box[dir_rows[i].box_sel][0], dir_box[dir_rows[i].box_sel][1],
                 dir_box[dir_rows[i].box_sel][2], dir_box[dir_rows[i].box_sel][3],
                 dir_box[dir_rows[i].box_sel][4], dir_box[dir_rows[i].box_sel][5]);
      send_vert(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].culled);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = idle_tx[ph];
      recv_idle = idle_rx[ph];
      for (int t = 0; t < 30; t++) begin
        if (t % 10 == 0) begin
          kind = $urandom_range(9);
          for (int ax = 0; ax < 3; ax++) begin
            a = rnd_coord(20);
            b = rnd_coord(20);
            if ($signed(a) > $signed(b)) begin
              lo[ax] = b; hi[ax] = a;
            end else begin
              lo[ax] = a; hi[ax] = b;
            end
            if (kind == 0) begin
              lo[ax] = 32'h80000000; hi[ax] = 32'h7FFFFFFF;
            end else if (kind == 1 && ax == ph) begin
              a = lo[ax]; lo[ax] = hi[ax]; hi[ax] = a;
            end else if (kind == 2) begin
              hi[ax] = lo[ax];
            end
          end
          load_box(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
        end
        // mostly near the box, some full range
        bits = ($urandom_range(99) < 80) ? 21 : 32;
        for (int v = 0; v < 3; v++)
          send_vert(rnd_coord(bits), rnd_coord(bits), rnd_coord(bits), 0);
      end
    end

    in_vert_if.valid <= 1'b0;
    while (clipped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[triangle_box_clipper_unit.f]
+incdir+rtl
rtl/tbc_pkg.sv
rtl/tbc_if.sv
rtl/tbc_front.sv
rtl/tbc_tri_fifo.sv
rtl/tbc_clip.sv
rtl/triangle_box_clipper_unit.sv
sim/tb_triangle_box_clipper_unit.sv
